### hw/rtl/h2r565_pkg.sv
package h2r565_pkg;

    // Field widths of the stream payload.
    localparam int HUE_W = 15;
    localparam int SAT_W = 13;
    localparam int VAL_W = 13;
    localparam int RGB_W = 16;

    // Packed and byte-padded widths of the slave-side tdata.
    localparam int S_FIELDS_W = HUE_W + SAT_W + VAL_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // Default number of fraction bits of saturation and value.
    localparam int FRAC_BITS_DEF = 12;

    // Hue arithmetic in sixteenths of a degree.
    localparam int HUE_FULL  = 5760;
    localparam int HUE_SIXTY = 960;
    // A normalized hue lies in 0..HUE_FULL.
    localparam int HUE_N_W   = 13;
    // Per-channel hue weight, 0..HUE_SIXTY.
    localparam int G_W       = 10;

    // Per-stage advance strobes of the pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } adv_t;

endpackage

### hw/rtl/h2r565_hue.sv
// Stage 1 wraps the hue into 0..360 degrees, stage 2 finds the sector and
// hands each channel its weight g: the channel value is V*(1 - S*g/960).
module h2r565_hue (
    input  logic                                 aclk,
    input  h2r565_pkg::adv_t                     adv,
    input  logic signed [h2r565_pkg::HUE_W-1:0]  hue,
    output logic [h2r565_pkg::G_W-1:0]           g_red,
    output logic [h2r565_pkg::G_W-1:0]           g_green,
    output logic [h2r565_pkg::G_W-1:0]           g_blue
);

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } sector_t;

    localparam int HW = h2r565_pkg::HUE_N_W;
    localparam int GW = h2r565_pkg::G_W;

    localparam logic signed [15:0] FULL1 = 16'(h2r565_pkg::HUE_FULL);
    localparam logic signed [15:0] FULL2 = 16'(2 * h2r565_pkg::HUE_FULL);
    localparam logic signed [15:0] FULL3 = 16'(3 * h2r565_pkg::HUE_FULL);

    localparam logic [HW-1:0] B1 = HW'(1 * h2r565_pkg::HUE_SIXTY);
    localparam logic [HW-1:0] B2 = HW'(2 * h2r565_pkg::HUE_SIXTY);
    localparam logic [HW-1:0] B3 = HW'(3 * h2r565_pkg::HUE_SIXTY);
    localparam logic [HW-1:0] B4 = HW'(4 * h2r565_pkg::HUE_SIXTY);
    localparam logic [HW-1:0] B5 = HW'(5 * h2r565_pkg::HUE_SIXTY);

    localparam logic [GW-1:0] G_FULL = GW'(h2r565_pkg::HUE_SIXTY);

    logic signed [15:0] h_ext;
    logic signed [15:0] h_wrap;
    logic [HW-1:0]      hn_reg;
    logic [HW-1:0]      hn_next;

    sector_t            sec;
    logic [HW-1:0]      base;
    logic [HW-1:0]      off;
    logic [GW-1:0]      g_x;
    logic [GW-1:0]      g_red_reg, g_green_reg, g_blue_reg;
    logic [GW-1:0]      g_red_next, g_green_next, g_blue_next;

    // A hue of exactly 360 degrees stays as it is; it lands in the last sector
    // with full weight (960) on the secondary channel, which is the colour of 0.
    always_comb begin
        h_ext = 16'(hue);
        if (h_ext > FULL1) begin
            if (h_ext >= FULL2) begin
                h_wrap = h_ext - FULL2;
            end else begin
                h_wrap = h_ext - FULL1;
            end
        end else if (h_ext < 16'sd0) begin
            if (h_ext >= -FULL1) begin
                h_wrap = h_ext + FULL1;
            end else if (h_ext >= -FULL2) begin
                h_wrap = h_ext + FULL2;
            end else begin
                h_wrap = h_ext + FULL3;
            end
        end else begin
            h_wrap = h_ext;
        end
        hn_next = h_wrap[HW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv.s1) begin
            hn_reg <= hn_next;
        end
    end

    always_comb begin
        if (hn_reg < B1) begin
            sec  = SEC_RY;
            base = '0;
        end else if (hn_reg < B2) begin
            sec  = SEC_YG;
            base = B1;
        end else if (hn_reg < B3) begin
            sec  = SEC_GC;
            base = B2;
        end else if (hn_reg < B4) begin
            sec  = SEC_CB;
            base = B3;
        end else if (hn_reg < B5) begin
            sec  = SEC_BM;
            base = B4;
        end else begin
            sec  = SEC_MR;
            base = B5;
        end
        off = hn_reg - base;
        // Rising sectors weight the secondary channel by 960 - offset,
        // falling sectors by the offset itself.
        if (sec[0]) begin
            g_x = off[GW-1:0];
        end else begin
            g_x = G_FULL - off[GW-1:0];
        end

        case (sec)
            SEC_RY: begin
                g_red_next = '0;     g_green_next = g_x;    g_blue_next = G_FULL;
            end
            SEC_YG: begin
                g_red_next = g_x;    g_green_next = '0;     g_blue_next = G_FULL;
            end
            SEC_GC: begin
                g_red_next = G_FULL; g_green_next = '0;     g_blue_next = g_x;
            end
            SEC_CB: begin
                g_red_next = G_FULL; g_green_next = g_x;    g_blue_next = '0;
            end
            SEC_BM: begin
                g_red_next = g_x;    g_green_next = G_FULL; g_blue_next = '0;
            end
            default: begin
                g_red_next = '0;     g_green_next = G_FULL; g_blue_next = g_x;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            g_red_reg   <= g_red_next;
            g_green_reg <= g_green_next;
            g_blue_reg  <= g_blue_next;
        end
    end

    assign g_red   = g_red_reg;
    assign g_green = g_green_reg;
    assign g_blue  = g_blue_reg;

endmodule

### hw/rtl/h2r565_chan.sv
// One colour channel. With T = 960*one - S*g and N = V*T, the 8-bit channel
// is round-half-up of 255*N/(960*one^2) = (17*N + 32*one^2) >> (2*FB + 6).
module h2r565_chan #(
    parameter int FRAC_BITS = h2r565_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  h2r565_pkg::adv_t                adv,
    input  logic [h2r565_pkg::SAT_W-1:0]    sat,
    input  logic [h2r565_pkg::VAL_W-1:0]    val,
    input  logic [h2r565_pkg::G_W-1:0]      g,
    output logic [7:0]                      chan
);

    localparam int SG_W = h2r565_pkg::SAT_W + h2r565_pkg::G_W;
    localparam int ONE_W = FRAC_BITS + h2r565_pkg::G_W;
    localparam int TW = ((ONE_W > SG_W) ? ONE_W : SG_W) + 1;
    localparam int NW = TW + h2r565_pkg::VAL_W + 1;
    localparam int RW = NW + 6;
    localparam int SH = 2 * FRAC_BITS + 6;
    localparam int QW = RW - SH;

    localparam logic signed [TW-1:0] C_ONE = TW'(h2r565_pkg::HUE_SIXTY) << FRAC_BITS;
    localparam logic signed [RW-1:0] RND = RW'(1) << (2 * FRAC_BITS + 5);

    logic [SG_W-1:0]          sg;
    logic signed [TW-1:0]     t_reg;
    logic signed [TW-1:0]     t_next;
    logic [h2r565_pkg::VAL_W-1:0] val_reg;
    logic signed [NW-1:0]     n_reg;
    logic signed [NW-1:0]     n_next;
    logic signed [RW-1:0]     acc;
    logic [QW-1:0]            q;

    always_comb begin
        sg     = SG_W'(sat) * SG_W'(g);
        t_next = C_ONE - $signed(TW'(sg));
    end

    always_ff @(posedge aclk) begin
        if (adv.s3) begin
            t_reg   <= t_next;
            val_reg <= val;
        end
    end

    assign n_next = NW'($signed({1'b0, val_reg})) * NW'(t_reg);

    always_ff @(posedge aclk) begin
        if (adv.s4) begin
            n_reg <= n_next;
        end
    end

    // A channel that comes out negative (saturation above one) clamps to zero.
    always_comb begin
        acc = (RW'(n_reg) <<< 4) + RW'(n_reg) + RND;
        q   = acc[RW-1:SH];
        if (n_reg[NW-1] || (n_reg == '0)) begin
            chan = '0;
        end else if (q > QW'(255)) begin
            chan = 8'hFF;
        end else begin
            chan = q[7:0];
        end
    end

endmodule

### hw/rtl/hsv_to_rgb565.sv
// HSV to RGB565 converter. Hue comes in sixteenths of a degree and is wrapped
// into 0..360 degrees; saturation and value are unsigned fractions with
// FRAC_BITS fraction bits. A saturation below 0.001 gives grey with each
// channel floor(255*V); otherwise a value below 0.001 gives black; otherwise
// each channel is 255*(channel + m) rounded half up, computed exactly, and the
// three channels are packed red 5, green 6, blue 5 bits. The block accepts one
// transaction per clock while the output is not stalled, and each result passes
// through five register stages: hue wrap, sector select, S*g product,
// V*T product and round/clamp/pack. Each stage holds its data under
// back-pressure and empty stages fill up, so a stall loses nothing.
module hsv_to_rgb565 #(
    parameter int FRAC_BITS = h2r565_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // hue[14:0], saturation[27:15], brightness[40:28], zero padding above
    input  logic [h2r565_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // rgb565[15:0]
    output logic [h2r565_pkg::RGB_W-1:0]        m_tdata
);

    localparam int SW = h2r565_pkg::SAT_W;
    localparam int VW = h2r565_pkg::VAL_W;
    localparam int GP_W = VW + 8;
    localparam int ONE = 1 << FRAC_BITS;
    localparam int LOW_LIM = (ONE - 1) / 1000 + 1;

    h2r565_pkg::adv_t adv;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic signed [h2r565_pkg::HUE_W-1:0] in_hue;
    logic [SW-1:0] in_sat;
    logic [VW-1:0] in_val;

    logic [GP_W-1:0] grey_prod;
    logic [GP_W-1:0] grey_shift;
    logic [7:0]      grey_next;
    logic            is_grey_next, is_black_next;

    logic [SW-1:0] sat1_reg, sat2_reg;
    logic [VW-1:0] val1_reg, val2_reg;
    logic [7:0]    grey1_reg, grey2_reg, grey3_reg, grey4_reg;
    logic          is_grey1_reg, is_grey2_reg, is_grey3_reg, is_grey4_reg;
    logic          is_black1_reg, is_black2_reg, is_black3_reg, is_black4_reg;

    logic [h2r565_pkg::G_W-1:0] g_red, g_green, g_blue;
    logic [7:0] red8, green8, blue8;

    logic [h2r565_pkg::RGB_W-1:0] rgb_reg;
    logic [h2r565_pkg::RGB_W-1:0] rgb_next;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        adv.s5 = !v5_reg || m_tready;
        adv.s4 = !v4_reg || adv.s5;
        adv.s3 = !v3_reg || adv.s4;
        adv.s2 = !v2_reg || adv.s3;
        adv.s1 = !v1_reg || adv.s2;
    end

    assign s_tready = adv.s1;
    assign m_tvalid = v5_reg;
    assign m_tdata  = rgb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (adv.s1) v1_reg <= s_tvalid;
            if (adv.s2) v2_reg <= v1_reg;
            if (adv.s3) v3_reg <= v2_reg;
            if (adv.s4) v4_reg <= v3_reg;
            if (adv.s5) v5_reg <= v4_reg;
        end
    end

    always_comb begin
        in_hue = $signed(s_tdata[h2r565_pkg::HUE_W-1:0]);
        in_sat = s_tdata[h2r565_pkg::HUE_W +: SW];
        in_val = s_tdata[h2r565_pkg::HUE_W + SW +: VW];

        grey_prod  = GP_W'(in_val) * GP_W'(255);
        grey_shift = grey_prod >> FRAC_BITS;
        if (grey_shift > GP_W'(255)) begin
            grey_next = 8'hFF;
        end else begin
            grey_next = grey_shift[7:0];
        end
        is_grey_next  = in_sat < SW'(LOW_LIM);
        is_black_next = in_val < VW'(LOW_LIM);
    end

    always_ff @(posedge aclk) begin
        if (adv.s1) begin
            sat1_reg      <= in_sat;
            val1_reg      <= in_val;
            grey1_reg     <= grey_next;
            is_grey1_reg  <= is_grey_next;
            is_black1_reg <= is_black_next;
        end
        if (adv.s2) begin
            sat2_reg      <= sat1_reg;
            val2_reg      <= val1_reg;
            grey2_reg     <= grey1_reg;
            is_grey2_reg  <= is_grey1_reg;
            is_black2_reg <= is_black1_reg;
        end
        if (adv.s3) begin
            grey3_reg     <= grey2_reg;
            is_grey3_reg  <= is_grey2_reg;
            is_black3_reg <= is_black2_reg;
        end
        if (adv.s4) begin
            grey4_reg     <= grey3_reg;
            is_grey4_reg  <= is_grey3_reg;
            is_black4_reg <= is_black3_reg;
        end
    end

    h2r565_hue u_hue (
        .aclk    (aclk),
        .adv     (adv),
        .hue     (in_hue),
        .g_red   (g_red),
        .g_green (g_green),
        .g_blue  (g_blue)
    );

    h2r565_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_red (
        .aclk (aclk),
        .adv  (adv),
        .sat  (sat2_reg),
        .val  (val2_reg),
        .g    (g_red),
        .chan (red8)
    );

    h2r565_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_green (
        .aclk (aclk),
        .adv  (adv),
        .sat  (sat2_reg),
        .val  (val2_reg),
        .g    (g_green),
        .chan (green8)
    );

    h2r565_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_blue (
        .aclk (aclk),
        .adv  (adv),
        .sat  (sat2_reg),
        .val  (val2_reg),
        .g    (g_blue),
        .chan (blue8)
    );

    // The grey test takes priority over the black test.
    always_comb begin
        if (is_grey4_reg) begin
            rgb_next = {grey4_reg[7:3], grey4_reg[7:2], grey4_reg[7:3]};
        end else if (is_black4_reg) begin
            rgb_next = '0;
        end else begin
            rgb_next = {red8[7:3], green8[7:2], blue8[7:3]};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.s5) begin
            rgb_reg <= rgb_next;
        end
    end

endmodule

### sim/hsv_to_rgb565_test.sv
`default_nettype none

module hsv_to_rgb565_test;
    timeunit 1ns;
    timeprecision 1ps;

    import h2r565_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int PAD_W       = S_TDATA_W - S_FIELDS_W;
    localparam int RANDOM_PIXELS = 1600;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [VAL_W-1:0] bri;
        logic [SAT_W-1:0] sat;
        logic [HUE_W-1:0] hue;
    } hsv_t;

    typedef struct {
        hsv_t             pixel;
        logic [RGB_W-1:0] rgb;
    } rgb_expect_t;

    class rgb565_tracker;
        rgb_expect_t pending_rgb[$];
        int          mismatches;

        function new();
            mismatches = 0;
        endfunction

        // One 8-bit channel: 255 * (ch + m) / den, rounded half up and clamped.
        function automatic logic [7:0] channel8(longint ch, longint m, longint den);
            longint num;
            longint val;
            num = ch + m;
            if (num <= 0)
                return 8'd0;
            val = (510 * num + den) / (2 * den);
            if (val > 255)
                val = 255;
            return val[7:0];
        endfunction

        function automatic logic [RGB_W-1:0] pack565(logic [7:0] r, logic [7:0] g,
                                                     logic [7:0] b);
            return {r[7:3], g[7:2], b[7:3]};
        endfunction

        function automatic logic [RGB_W-1:0] predict_rgb565(hsv_t px);
            int     h;
            int     rem;
            int     f;
            longint s;
            longint v;
            longint one;
            longint den;
            longint c_term;
            longint x_term;
            longint m_term;
            longint r_term;
            longint g_term;
            longint b_term;
            longint grey;
            h   = $signed(px.hue);
            s   = px.sat;
            v   = px.bri;
            one = longint'(1) << FRAC;
            if (s * 1000 < one) begin
                grey = (255 * v) >>> FRAC;
                if (grey > 255)
                    grey = 255;
                return pack565(grey[7:0], grey[7:0], grey[7:0]);
            end
            if (v * 1000 < one)
                return '0;
            if (h > HUE_FULL)
                h = h % HUE_FULL;
            if (h < 0)
                h = ((h % HUE_FULL) + HUE_FULL) % HUE_FULL;
            den    = longint'(HUE_SIXTY) << (2 * FRAC);
            rem    = h % (2 * HUE_SIXTY);
            f      = HUE_SIXTY - ((rem >= HUE_SIXTY) ? rem - HUE_SIXTY : HUE_SIXTY - rem);
            c_term = v * s * HUE_SIXTY;
            x_term = v * s * f;
            m_term = v * one * HUE_SIXTY - c_term;
            if (h < HUE_SIXTY) begin
                r_term = c_term; g_term = x_term; b_term = 0;
            end else if (h < 2 * HUE_SIXTY) begin
                r_term = x_term; g_term = c_term; b_term = 0;
            end else if (h < 3 * HUE_SIXTY) begin
                r_term = 0; g_term = c_term; b_term = x_term;
            end else if (h < 4 * HUE_SIXTY) begin
                r_term = 0; g_term = x_term; b_term = c_term;
            end else if (h < 5 * HUE_SIXTY) begin
                r_term = x_term; g_term = 0; b_term = c_term;
            end else begin
                r_term = c_term; g_term = 0; b_term = x_term;
            end
            return pack565(channel8(r_term, m_term, den), channel8(g_term, m_term, den),
                           channel8(b_term, m_term, den));
        endfunction

        function void note_pixel(hsv_t px);
            rgb_expect_t e;
            e.pixel = px;
            e.rgb   = predict_rgb565(px);
            pending_rgb.push_back(e);
        endfunction

        function void check_pixel(logic [RGB_W-1:0] rgb);
            rgb_expect_t e;
            if (pending_rgb.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result rgb565=%h", rgb);
                return;
            end
            e = pending_rgb.pop_front();
            if (rgb !== e.rgb) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: hue=%0d sat=%0d val=%0d expected rgb565=%h got %h",
                             $signed(e.pixel.hue), e.pixel.sat, e.pixel.bri, e.rgb, rgb);
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [RGB_W-1:0]     m_tdata;

    rgb565_tracker tracker = new();
    int            pixels_in = 0;
    int            idle_cycles = 0;
    bit            sender_calm = 0;

    hsv_to_rgb565 uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_pixel(input int h, input int s, input int b);
        hsv_t px;
        int   gap;
        px.hue = h[HUE_W-1:0];
        px.sat = s[SAT_W-1:0];
        px.bri = b[VAL_W-1:0];
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, px};
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    task automatic send_random_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            send_pixel($urandom_range(0, 17279) - 5760, $urandom_range(0, 4096),
                       $urandom_range(0, 4096));
        else if (r < 85)
            send_pixel($urandom_range(0, 17279) - 5760, $urandom_range(0, 8),
                       $urandom_range(0, 8));
        else
            send_pixel($urandom(), $urandom(), $urandom());
    endtask

    // Both channels are sampled at the clock edge, before any update lands.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tracker.note_pixel(hsv_t'(s_tdata[S_FIELDS_W-1:0]));
                pixels_in++;
            end
            if (m_tvalid && m_tready)
                tracker.check_pixel(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Result side: random stalls, long ready stretches, and one long hold-off
    // that lets the pipeline fill and push back on the sender.
    initial begin
        int r;
        int n;
        bit held;
        held = 0;
        m_tready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!held && pixels_in >= HOLD_AT) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    m_tready <= 1'b1;
                    n = $urandom_range(100, 300);
                end else if (r < 60) begin
                    m_tready <= 1'b1;
                    n = $urandom_range(1, 8);
                end else begin
                    m_tready <= 1'b0;
                    n = 1 + pick_gap();
                end
                repeat (n) @(posedge aclk);
            end
        end
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sector edges, hue wrap in both directions, and both extremes of the field.
        send_pixel(0, 4096, 4096);
        send_pixel(480, 4096, 4096);
        send_pixel(959, 4096, 4096);
        send_pixel(960, 4096, 4096);
        send_pixel(1919, 3000, 4096);
        send_pixel(2400, 2048, 3000);
        send_pixel(3360, 4096, 2048);
        send_pixel(4320, 1000, 4096);
        send_pixel(5280, 4096, 1234);
        send_pixel(5760, 4096, 4096);
        send_pixel(5761, 4096, 4096);
        send_pixel(11519, 4096, 4096);
        send_pixel(-1, 4096, 4096);
        send_pixel(-5760, 4096, 4096);
        send_pixel(-16384, 3000, 3000);
        send_pixel(16383, 3000, 3000);
        // Grey and black thresholds, grey taking precedence.
        send_pixel(1000, 4, 4096);
        send_pixel(1000, 0, 0);
        send_pixel(1000, 5, 4096);
        send_pixel(1000, 4096, 4);
        send_pixel(1000, 4096, 5);
        send_pixel(1000, 0, 8191);
        // Saturation and value above one force clamping.
        send_pixel(1500, 8191, 4096);
        send_pixel(4000, 8191, 8191);
        send_pixel(200, 6000, 8191);

        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            if (i % 200 == 0)
                sender_calm = ($urandom_range(0, 3) == 0);
            send_random_pixel();
        end
        s_tvalid <= 1'b0;

        while (tracker.pending_rgb.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (tracker.mismatches == 0 && tracker.pending_rgb.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
